/* src/sat_pkg.sv */
// shared types and constants of the sleep alarm table
`default_nettype none

package sat_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [0:0] {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    KIND_WOKEN    = 1'b0,
    KIND_REJECTED = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  thread_id;
    logic [63:0] start_tick;
    logic [63:0] sleep_ticks;
    logic [63:0] now_tick;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] woken_id;
    logic       last;
  } res_t;

  // payload of one table slot
  typedef struct packed {
    logic [7:0]  thread_id;
    logic [63:0] start_tick;
    logic [63:0] interval;
  } entry_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic shift;
    logic ins;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/sleep_alarm_table_core.sv */
// top level of the sleep alarm table: chain of slot cells and scan control
// sleep request: taken while idle, a full-table reject appears on the next cycle
// tick: accept, one scan step per stored entry, one flush; busy during scan and flush;
//   no scan when the table is empty; the head cell checks one entry per cycle
// wake results one per cycle at most, last one right after the flush, no stall
// reset clears all valid bits and control at once, no clearing pass
`default_nettype none

module sleep_alarm_table_core #(
  parameter int unsigned DEPTH = sat_pkg::DefaultDepth
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  sat_pkg::req_t req_i,
  output logic          res_valid_o,
  output sat_pkg::res_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // chain wiring
  logic [DEPTH-1:0]   vld;
  logic [DEPTH-1:0]   pred_ok;
  logic [DEPTH-1:0]   nxt_vld;
  sat_pkg::entry_t    ent     [DEPTH];
  sat_pkg::entry_t    nxt_ent [DEPTH];
  sat_pkg::cell_ctl_t ctl;
  sat_pkg::entry_t    ins_entry;

  // control state
  sat_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;     // number of valid slots
  logic [CntW-1:0] rem_q, rem_d;     // entries left to check in this scan
  logic [63:0]     now_q, now_d;
  logic            pend_q, pend_d;   // one woken id held back to learn its last flag
  logic [7:0]      pend_id_q, pend_id_d;
  logic            out_vld_q, out_vld_d;
  sat_pkg::res_t   out_q, out_d;

  logic [63:0] head_age;
  logic        head_expired;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // slot i takes a new entry only when the slot in front of it is occupied
    // (after the shift, that front slot holds what is now in slot i)
    if (i == 0) begin : g_head
      assign pred_ok[i] = 1'b1;
    end else begin : g_body
      assign pred_ok[i] = ctl.shift ? vld[i] : vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nxt_vld[i] = 1'b0;
      assign nxt_ent[i] = '0;
    end else begin : g_link
      assign nxt_vld[i] = vld[i+1];
      assign nxt_ent[i] = ent[i+1];
    end

    sat_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .ins_entry_i (ins_entry),
      .pred_ok_i   (pred_ok[i]),
      .nxt_valid_i (nxt_vld[i]),
      .nxt_entry_i (nxt_ent[i]),
      .valid_o     (vld[i]),
      .entry_o     (ent[i])
    );
  end

  // age of the head entry wraps modulo 2^64
  assign head_age     = now_q - ent[0].start_tick;
  assign head_expired = head_age >= ent[0].interval;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    now_d     = now_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    ctl       = '0;
    if (state_q == sat_pkg::ST_SCAN) begin
      // kept head entries go back in behind the remaining ones
      ins_entry = ent[0];
    end else begin
      ins_entry.thread_id  = req_i.thread_id;
      ins_entry.start_tick = req_i.start_tick;
      ins_entry.interval   = req_i.sleep_ticks;
    end

    case (state_q)
      sat_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.op == sat_pkg::OP_SLEEP) begin
            if (cnt_q == CntW'(DEPTH)) begin
              out_vld_d      = 1'b1;
              out_d.kind     = sat_pkg::KIND_REJECTED;
              out_d.woken_id = req_i.thread_id;
              out_d.last     = 1'b1;
            end else begin
              ctl.ins = 1'b1;
              cnt_d   = cnt_q + CntW'(1);
            end
          end else if (cnt_q != '0) begin
            now_d   = req_i.now_tick;
            rem_d   = cnt_q;
            pend_d  = 1'b0;
            state_d = sat_pkg::ST_SCAN;
          end
        end
      end

      sat_pkg::ST_SCAN: begin
        // pop the head each cycle; expired entries are dropped
        ctl.shift = 1'b1;
        ctl.ins   = ~head_expired;
        rem_d     = rem_q - CntW'(1);
        if (head_expired) begin
          cnt_d = cnt_q - CntW'(1);
          if (pend_q) begin
            out_vld_d      = 1'b1;
            out_d.kind     = sat_pkg::KIND_WOKEN;
            out_d.woken_id = pend_id_q;
            out_d.last     = 1'b0;
          end
          pend_d    = 1'b1;
          pend_id_d = ent[0].thread_id;
        end
        if (rem_q == CntW'(1)) begin
          state_d = sat_pkg::ST_FLUSH;
        end
      end

      sat_pkg::ST_FLUSH: begin
        // the held id is the final one of this tick
        if (pend_q) begin
          out_vld_d      = 1'b1;
          out_d.kind     = sat_pkg::KIND_WOKEN;
          out_d.woken_id = pend_id_q;
          out_d.last     = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = sat_pkg::ST_IDLE;
      end

      default: begin
        state_d = sat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sat_pkg::ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign busy        = state_q != sat_pkg::ST_IDLE;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

`ifndef SYNTHESIS
  logic [DEPTH-1:0] vld_inc;
  assign vld_inc = vld + DEPTH'(1);

  // occupied slots always form a prefix of the chain
  a_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & vld_inc) == '0)
    else $error("valid slots do not form a prefix");

  // slot count tracks the chain contents
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(vld)))
    else $error("slot count out of step with valid bits");

  // a result not flagged last only comes out of a running scan
  a_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |->
      (state_q == sat_pkg::ST_SCAN || state_q == sat_pkg::ST_FLUSH))
    else $error("unterminated result outside a scan");

  // a sleep transfer never changes the count by more than one
  a_sleep_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == sat_pkg::OP_SLEEP) |=>
      (cnt_q == $past(cnt_q) + CntW'(1) || (res_valid_o && res_o.kind == sat_pkg::KIND_REJECTED)))
    else $error("sleep transfer lost or mis-counted");
`endif

endmodule

`default_nettype wire

/* src/sat_cell.sv */
// one slot of the sleep table chain
`default_nettype none

module sat_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  sat_pkg::cell_ctl_t ctl_i,
  input  sat_pkg::entry_t  ins_entry_i,
  input  wire              pred_ok_i,
  input  wire              nxt_valid_i,
  input  sat_pkg::entry_t  nxt_entry_i,
  output logic             valid_o,
  output sat_pkg::entry_t  entry_o
);

  logic            vld_q, vld_d;
  sat_pkg::entry_t ent_q, ent_d;
  logic            load_nxt, load_ins;

  always_comb begin
    load_nxt = ctl_i.shift & nxt_valid_i;
    // new entry lands on the first free slot behind the valid prefix
    load_ins = ctl_i.ins & pred_ok_i & (ctl_i.shift ? ~nxt_valid_i : ~vld_q);
    vld_d    = ctl_i.shift ? (nxt_valid_i | load_ins) : (vld_q | load_ins);
    if (load_nxt) begin
      ent_d = nxt_entry_i;
    end else if (load_ins) begin
      ent_d = ins_entry_i;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign valid_o = vld_q;
  assign entry_o = ent_q;

endmodule

`default_nettype wire
